// File: rtl/double_ended_queue_assert.svh
// Assertion macros included by the deque top module.
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication, checked out of reset.
`define DQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

// File: rtl/dq_pkg.sv
// Types and constants of the double-ended queue.
package dq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_REAR  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_REAR   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Operation broadcast to every cell; only legal operations are issued.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } link_t;

endpackage

// File: rtl/dq_cell.sv
// One storage cell of the deque shift row.
module dq_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dq_pkg::cmd_t              cmd_i,
  input  dq_pkg::link_t             left_i,   // toward the front
  input  dq_pkg::link_t             right_i,  // toward the rear
  output dq_pkg::link_t             self_o,
  output logic [dq_pkg::DATA_W-1:0] tail_data_o
);
  import dq_pkg::*;

  logic              valid_q, valid_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic              is_tail;

  assign is_tail = valid_q && !right_i.valid;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    unique case (cmd_i.op)
      OP_PUSH_FRONT: begin
        valid_d = left_i.valid;
        data_d  = left_i.data;
      end
      OP_PUSH_REAR: begin
        // first empty slot behind an occupied one takes the beat
        if (!valid_q && left_i.valid) begin
          valid_d = 1'b1;
          data_d  = cmd_i.value;
        end
      end
      OP_POP_FRONT: begin
        valid_d = right_i.valid;
        data_d  = right_i.data;
      end
      OP_POP_REAR: begin
        if (is_tail) valid_d = 1'b0;
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign self_o.valid = valid_q;
  assign self_o.data  = data_q;
  assign tail_data_o  = is_tail ? data_q : '0;

endmodule

// File: rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit entries built as a shift row of cells.
//
// The deque holds up to DEPTH (16) entries in a row of identical cells. The
// front entry always sits in cell 0 and entries fill the row without gaps,
// so a push at the front or a pop from the front shifts every cell by one
// place toward its neighbor, while a push or pop at the rear only touches
// the cell at the end of the occupied run. Each accepted beat is one of
// push front, push rear, pop front or pop rear and yields exactly one
// result beat: the popped value (zero for pushes and failed pops), a status
// (ok, pop on empty, push on full dropped) and the occupancy afterwards.
// A push onto a full deque or a pop from an empty one leaves the contents
// untouched. One operation is taken every clock cycle unless stalled; its
// result appears in the output register on the next cycle. The row of
// cells updates with that register, so throughput is set only by the output
// register: a new beat is taken whenever it is empty or being drained. No
// clearing pass runs after reset; the block is ready at once.
module double_ended_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // operation channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                mode_i,
  input  logic signed [31:0]        value_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [31:0]        popped_value_o,
  output logic [1:0]                status_o,
  output logic [dq_pkg::CNT_W-1:0]  occupancy_o
);
  import dq_pkg::*;

  // handshake
  logic accept;

  // entry count
  logic [CNT_W-1:0] count_q, count_d;
  logic             full, empty;

  // broadcast command and cell row
  cmd_t              cmd;
  status_e           status;
  link_t             cell_lnk  [DEPTH];
  logic [DATA_W-1:0] tail_data [DEPTH];
  logic [DATA_W-1:0] tail_any;
  logic [DATA_W-1:0] popped;
  logic [DEPTH-1:0]  valid_vec;

  // output register
  logic              out_valid_q;
  logic [DATA_W-1:0] popped_q;
  status_e           status_q;
  logic [CNT_W-1:0]  occ_q;

  // The output register is the only stall point: take a beat when it is
  // empty or its content leaves this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // Decode mode into a legal cell operation; illegal ones become no-ops.
  always_comb begin
    cmd.op    = OP_NONE;
    cmd.value = value_i;
    status    = ST_OK;
    count_d   = count_q;
    unique case (mode_e'(mode_i))
      MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
        if (full) begin
          status = ST_FULL;
        end else if (accept) begin
          cmd.op  = (mode_e'(mode_i) == MODE_PUSH_FRONT) ? OP_PUSH_FRONT : OP_PUSH_REAR;
          count_d = count_q + 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_POP_REAR: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (accept) begin
          cmd.op  = (mode_e'(mode_i) == MODE_POP_FRONT) ? OP_POP_FRONT : OP_POP_REAR;
          count_d = count_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Row of cells: cell 0 sees the incoming value as its front neighbor so a
  // push at the front shifts it in; the last cell sees an empty rear.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t left, right;
    if (i == 0) begin : g_head
      assign left.valid = 1'b1;
      assign left.data  = value_i;
    end else begin : g_mid_l
      assign left = cell_lnk[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right.valid = 1'b0;
      assign right.data  = '0;
    end else begin : g_mid_r
      assign right = cell_lnk[i+1];
    end

    dq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left),
      .right_i     (right),
      .self_o      (cell_lnk[i]),
      .tail_data_o (tail_data[i])
    );

    assign valid_vec[i] = cell_lnk[i].valid;
  end

  // At most one cell marks itself as the rear, so an OR picks its data.
  always_comb begin
    tail_any = '0;
    for (int i = 0; i < DEPTH; i++) tail_any |= tail_data[i];
  end

  always_comb begin
    popped = '0;
    if (cmd.op == OP_POP_FRONT) popped = cell_lnk[0].data;
    if (cmd.op == OP_POP_REAR)  popped = tail_any;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped;
      status_q <= status;
      occ_q    <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign occupancy_o    = occ_q;

`include "double_ended_queue_assert.svh"

  // count register agrees with the occupied cells
  `DQ_ASSERT_IMP(a_count_cells, 1'b1, $countones(valid_vec) == int'(count_q))
  // occupied cells form one run starting at the front
  `DQ_ASSERT_IMP(a_cells_packed, 1'b1, (valid_vec & (valid_vec + 1'b1)) == '0)
  // a dropped push is reported only on a full deque
  `DQ_ASSERT_IMP(a_full_occ, out_valid_q && status_q == ST_FULL, occ_q == CNT_W'(DEPTH))
  // every accepted beat produces a result
  `DQ_ASSERT_NXT(a_result, accept, out_valid_q)

endmodule
